// ===== rtl/piet_pkg.sv =====
// Package for the per-entry importance tracker: word types, constants, opcodes.
// No dependencies.
`default_nettype none
package piet_pkg;
  localparam int unsigned ENTRY_COUNT_DEF   = 4096;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam logic [1:0] REG_FAST_DECAY      = 2'd0;
  localparam logic [1:0] REG_FAST_SHARE      = 2'd1;
  localparam logic [1:0] REG_EMPTY_THRESHOLD = 2'd2;

  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_ANSWER  = 1'b1;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic        opcode;
    logic [11:0] entry_index;
    logic signed [31:0] raw_value;
    logic [15:0] hit_count;
    logic [30:0] frame_number;
    logic        frame_end;
  } in_word_t;

  typedef struct packed {
    logic        answer_kind;
    logic [12:0] observed_total;
    logic        frame_rejected;
    logic signed [31:0] combined_score;
    logic        fast_seen;
    logic        slow_seen;
    logic signed [31:0] last_seen;
  } out_word_t;

  // Per-entry history word held in the history memory.
  typedef struct packed {
    logic               seen;     // last_seen valid (not -1)
    logic [30:0]        last;
    logic signed [31:0] fast;
    logic signed [31:0] slow;
    logic [30:0]        count;
  } hist_t;

  // Frame store word: epoch mark plus raw value.
  typedef struct packed {
    logic               epoch;
    logic signed [31:0] raw;
  } frame_t;
endpackage
`default_nettype wire

// ===== rtl/piet_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module piet_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/piet_div.sv =====
// Unsigned restoring divider, one quotient bit a cycle: q = num / den.
// No dependencies.
`default_nettype none
module piet_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo
);
  logic [NW-1:0]          n_sh;
  logic [DW:0]            rem;
  logic [DW-1:0]          d;
  logic [$clog2(NW+1)-1:0] cnt;
  logic [DW:0]            trial;

  assign trial = {rem[DW-1:0], n_sh[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ($clog2(NW+1))'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == ($clog2(NW+1))'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_sh <= num;
      rem  <= '0;
      d    <= den;
      quo  <= '0;
    end else if (busy) begin
      n_sh <= n_sh << 1;
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/per_entry_importance_tracker.sv =====
// Top level of the per-entry importance tracker: control sequencer,
// frame store and history memories. Uses piet_pkg, piet_ram, piet_div.
//
//  channel | dir | handshake           | word
//  in      | in  | in_valid/in_stall   | in_word_t
//  out     | out | out_valid/out_stall | out_word_t
//  cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// Frame elements: each passes accept, frame store read and update before the next accept.
// Queries: accept, then history read, then the result word is registered for output.
// A closing element with observed entries walks all ENTRY_COUNT entries, reading and
// checking each; a marked entry of an accepted frame takes two passes through the shared
// bit-serial divider, a marked entry of a rejected frame takes none.
// After reset a clearing pass over all ENTRY_COUNT entries sets both memories; no item is taken.
// Results wait in one output register; the block stalls input while it is full.
`default_nettype none
module per_entry_importance_tracker
  import piet_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT   = ENTRY_COUNT_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);
  localparam int unsigned AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned NW = 64 + FRACTION_BITS;
  localparam int unsigned HW = $bits(hist_t);
  localparam int unsigned FW = $bits(frame_t);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_ELEM = 4'd2,
    S_ELEM2 = 4'd3, S_QRY = 4'd4, S_QRY2 = 4'd5, S_CLOSE = 4'd6,
    S_WRD = 4'd7, S_WCHK = 4'd8, S_WDIV1 = 4'd9, S_WFAST = 4'd10,
    S_WDIV2 = 4'd11, S_WWR = 4'd12, S_OUT = 4'd13, S_WMUL = 4'd14;

  logic [3:0] state;
  logic [16:0] fast_decay, fast_share;
  logic [30:0] empty_threshold;
  in_word_t    cur;
  logic        epoch;
  logic        reject;
  logic signed [47:0] frame_sum;
  logic [12:0] frame_observed;
  logic [AW:0] walk;
  logic [AW-1:0] addr;

  // cfg
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_decay      <= 17'd58982;
      fast_share      <= 17'd32768;
      empty_threshold <= 31'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAST_DECAY:      fast_decay <= cfg_data[16:0];
        REG_FAST_SHARE:      fast_share <= cfg_data[16:0];
        REG_EMPTY_THRESHOLD: empty_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [16:0] decay, share;
  logic signed [48:0] eps;
  assign decay = (fast_decay > ONE_Q16) ? ONE_Q16 : fast_decay;
  assign share = (fast_share > ONE_Q16) ? ONE_Q16 : fast_share;
  assign eps   = (empty_threshold == '0) ? 49'sd1 : 49'(empty_threshold);

  // memories
  logic   f_we, h_we;
  frame_t f_wd, f_rd;
  hist_t  h_wd, h_rd;
  logic [AW-1:0] f_wa, h_wa;

  piet_ram #(.WIDTH(FW), .DEPTH(ENTRY_COUNT)) u_frame (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(addr), .rdata(f_rd));
  piet_ram #(.WIDTH(HW), .DEPTH(ENTRY_COUNT)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(addr), .rdata(h_rd));

  // divider
  logic dv_start, dv_busy;
  logic [NW-1:0] dv_num, dv_quo;
  logic [63:0]   dv_den;
  piet_div #(.NW(NW), .DW(64)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quo(dv_quo));

  logic in_range;
  assign in_range = ({8'd0, cur.entry_index} < 20'(ENTRY_COUNT)) || (ENTRY_COUNT >= 4096);

  // frame-store mark valid when epoch bit matches current epoch
  logic marked;
  assign marked = (f_rd.epoch == epoch);

  // walk datapath registers
  logic signed [31:0] score, fast_new, old_slow;
  logic [30:0] cnt_new;
  logic        neg;
  logic signed [49:0] den_s;
  logic [63:0] den_mag;
  logic signed [50:0] prod;
  logic signed [33:0] diff;
  hist_t hcur;

  assign den_s   = 50'(frame_sum) + 50'(eps);
  assign den_mag = den_s[49] ? 64'(-den_s) : 64'(den_s);

  logic [31:0] raw_mag;
  assign raw_mag = f_rd.raw[31] ? 32'(-33'(f_rd.raw)) : f_rd.raw[31:0];

  // score saturation from quotient
  logic signed [31:0] sc_val;
  always_comb begin
    if (neg) sc_val = (dv_quo > NW'(32'h8000_0000)) ? 32'sh8000_0000
                                                   : 32'(-33'(dv_quo[31:0]));
    else     sc_val = (dv_quo > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                   : 32'(dv_quo[31:0]);
  end

  logic [33:0] diff_mag_s_next;
  logic signed [33:0] d_now;
  assign d_now = 34'(score) - 34'(hcur.slow);
  assign diff_mag_s_next = d_now[33] ? 34'(-d_now) : 34'(d_now);

  logic [47:0] sum_abs;
  assign sum_abs = frame_sum[47] ? 48'(-frame_sum) : 48'(frame_sum);

  // query combination products
  logic signed [50:0] qa, qb;
  logic signed [51:0] qs;
  assign qa = $signed({1'b0, share}) * h_rd.fast;
  assign qb = $signed({1'b0, 17'(ONE_Q16 - share)}) * h_rd.slow;
  assign qs = 52'(qa) + 52'(qb);

  logic signed [51:0] qs_div;
  assign qs_div = qs / 52'sd65536;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      walk      <= '0;
      epoch     <= 1'b1;
      frame_sum <= '0;
      frame_observed <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          walk <= walk + 1'b1;
          if (walk == (AW+1)'(ENTRY_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && !in_stall) begin
          state <= (in_word.opcode == OP_QUERY) ? S_QRY : S_ELEM;
        end
        S_ELEM: state <= S_ELEM2;
        S_ELEM2: begin
          if (in_range) begin
            logic signed [47:0] s;
            logic [12:0] o;
            s = frame_sum;
            o = frame_observed;
            if (marked) begin
              s = s - 48'(f_rd.raw);
              o = o - 1'b1;
            end
            if (cur.hit_count != '0) begin
              s = s + 48'(cur.raw_value);
              o = o + 1'b1;
            end
            frame_sum <= s;
            frame_observed <= o;
          end
          state <= cur.frame_end ? S_CLOSE : S_IDLE;
        end
        S_QRY: state <= S_QRY2;
        S_QRY2: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_CLOSE: begin
          if (frame_observed == '0) begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            // a rejected frame still walks to drop its marks
            reject <= (49'(sum_abs) <= eps);
            walk  <= '0;
            state <= S_WRD;
          end
        end
        S_WRD: state <= S_WCHK;
        S_WCHK: begin
          if (marked && !reject) state <= S_WDIV1;
          else if (walk == (AW+1)'(ENTRY_COUNT - 1)) begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            walk <= walk + 1'b1;
            state <= S_WRD;
          end
        end
        S_WDIV1: if (!dv_busy && !dv_start) state <= S_WMUL;
        S_WMUL: state <= S_WFAST;
        S_WFAST: state <= S_WDIV2;
        S_WDIV2: if (!dv_busy && !dv_start) state <= S_WWR;
        S_WWR: begin
          if (walk == (AW+1)'(ENTRY_COUNT - 1)) begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            walk <= walk + 1'b1;
            state <= S_WRD;
          end
        end
        S_OUT: begin
          frame_sum <= '0;
          frame_observed <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider sequencing flag: start pulses on entry to a divide state
  logic dv_go;
  always_ff @(posedge clk) begin
    if (rst) dv_go <= 1'b0;
    else dv_go <= (state == S_WCHK && marked && !reject) || (state == S_WFAST);
  end
  assign dv_start = dv_go;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !in_stall) cur <= in_word;
    if (state == S_WCHK) begin
      hcur <= h_rd;
      neg  <= f_rd.raw[31] ^ den_s[49];
      dv_num <= NW'({32'd0, raw_mag} * 64'(frame_observed)) << FRACTION_BITS;
      dv_den <= den_mag;
      cnt_new <= (h_rd.count == 31'h7FFF_FFFF) ? h_rd.count : h_rd.count + 1'b1;
    end
    if (state == S_WDIV1 && !dv_busy && !dv_start) begin
      score <= sc_val;
      prod  <= $signed({1'b0, decay}) * hcur.fast;
    end
    if (state == S_WMUL) begin
      prod <= prod + $signed({1'b0, 17'(ONE_Q16 - decay)}) * score;
    end
    if (state == S_WFAST) begin
      fast_new <= hcur.seen ? 32'(prod / 51'sd65536) : score;
      old_slow <= hcur.slow;
      diff     <= 34'(score) - 34'(hcur.slow);
      dv_num   <= NW'(diff_mag_s_next);
      dv_den   <= 64'(cnt_new);
    end
  end

  logic signed [33:0] dq_signed;
  assign dq_signed = diff[33] ? -$signed(34'(dv_quo)) : $signed(34'(dv_quo));

  // addresses
  always_comb begin
    addr = '0;
    unique case (state)
      S_CLEAR, S_WRD, S_WCHK, S_WDIV1, S_WMUL, S_WFAST, S_WDIV2, S_WWR:
        addr = walk[AW-1:0];
      S_IDLE:  addr = in_word.entry_index[AW-1:0];
      default: addr = cur.entry_index[AW-1:0];
    endcase
  end

  always_comb begin
    f_we = 1'b0;
    f_wa = cur.entry_index[AW-1:0];
    f_wd.epoch = epoch;
    f_wd.raw   = cur.raw_value;
    h_we = 1'b0;
    h_wa = walk[AW-1:0];
    h_wd.seen  = 1'b1;
    h_wd.last  = cur.frame_number;
    h_wd.fast  = fast_new;
    h_wd.slow  = 32'(34'(old_slow) + dq_signed);
    h_wd.count = cnt_new;
    if (state == S_ELEM2 && in_range) begin
      f_we = 1'b1;
      f_wd.epoch = (cur.hit_count != '0) ? epoch : ~epoch;
    end
    if (state == S_WWR) h_we = 1'b1;
    if (state == S_WCHK && marked) begin
      // drop the mark so the next frame starts empty
      f_we = 1'b1;
      f_wa = walk[AW-1:0];
      f_wd.epoch = ~epoch;
      f_wd.raw   = f_rd.raw;
    end
    if (state == S_CLEAR) begin
      h_we = 1'b1;
      h_wd = '0;
      f_we = 1'b1;
      f_wa = walk[AW-1:0];
      f_wd.epoch = 1'b0;
      f_wd.raw = '0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == S_QRY2) begin
      out_word <= '0;
      out_word.answer_kind <= KIND_ANSWER;
      if (!in_range) begin
        out_word.last_seen <= -32'sd1;
      end else begin
        out_word.fast_seen <= h_rd.seen;
        out_word.slow_seen <= (h_rd.count != '0);
        out_word.last_seen  <= h_rd.seen ? {1'b0, h_rd.last} : -32'sd1;
        if (h_rd.seen && h_rd.count != '0) out_word.combined_score <= 32'(qs_div);
        else if (h_rd.seen) out_word.combined_score <= h_rd.fast;
        else if (h_rd.count != '0) out_word.combined_score <= h_rd.slow;
      end
    end else if (state == S_CLOSE || state == S_WCHK || state == S_WWR) begin
      out_word <= '0;
      out_word.answer_kind <= KIND_SUMMARY;
      if (frame_observed != '0 && 49'(sum_abs) <= eps) out_word.frame_rejected <= 1'b1;
      else out_word.observed_total <= frame_observed;
    end
  end

  assign in_stall = (state != S_IDLE) || out_valid;

  property p_hold; @(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word); endproperty
  a_hold: assert property (p_hold) else $error("result dropped while stalled");
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("input taken while busy");
  a_obs: assert property (@(posedge clk) disable iff (rst)
    frame_observed <= 13'(ENTRY_COUNT)) else $error("observed count overflow");
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for per_entry_importance_tracker: random and directed frames and queries
// against a built-in score predictor. Depends on piet_pkg and the tracker RTL.
module testbench;
  import piet_pkg::*;

  localparam int NENT = 4096;
  localparam int WATCH_LIMIT = 100000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_FAST_DECAY;
  logic [30:0] cfg_data = '0;

  always #2 clk = ~clk;

  per_entry_importance_tracker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // tracker state as the predictor sees it
  int unsigned decay_reg, share_reg, eps_reg;
  int fast_s[NENT];
  int slow_m[NENT];
  int unsigned slow_c[NENT];
  int last_f[NENT];
  int raw_s[NENT];
  bit mark[NENT];
  int marked_list[$];
  longint frame_sum;
  int frame_obs;

  in_word_t word_q[$];
  out_word_t expected_q[$];
  int n_queued, n_taken, n_errors;
  bit quiet;

  function automatic int frame_score(int raw, int n, longint den);
    longint unsigned mr, md;
    logic [127:0] q;
    bit neg;
    neg = (raw < 0) != (den < 0);
    mr = (raw < 0) ? longint'(-longint'(raw)) : longint'(raw);
    md = (den < 0) ? -den : den;
    q = ((128'(mr) * 128'(n)) << 16) / 128'(md);
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return int'(-longint'(q[63:0]));
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return int'(q[31:0]);
  endfunction

  function automatic void track_word(in_word_t w);
    out_word_t r;
    int idx, x;
    longint dec, shr, eps, mag, den, f, s, old;
    idx = int'(w.entry_index);
    dec = (decay_reg > 65536) ? 65536 : decay_reg;
    shr = (share_reg > 65536) ? 65536 : share_reg;
    eps = (eps_reg == 0) ? 1 : eps_reg;
    r = '0;
    if (w.opcode == OP_QUERY) begin
      r.answer_kind = KIND_ANSWER;
      r.fast_seen = last_f[idx] >= 0;
      r.slow_seen = slow_c[idx] > 0;
      f = fast_s[idx];
      s = slow_m[idx];
      if (r.fast_seen && r.slow_seen)
        r.combined_score = int'((shr * f + (65536 - shr) * s) / 65536);
      else if (r.fast_seen) r.combined_score = int'(f);
      else if (r.slow_seen) r.combined_score = int'(s);
      r.last_seen = last_f[idx];
      expected_q.push_back(r);
      return;
    end
    if (mark[idx]) begin
      frame_sum -= raw_s[idx];
      frame_obs--;
      mark[idx] = 0;
    end
    if (w.hit_count != 0) begin
      raw_s[idx] = w.raw_value;
      mark[idx] = 1;
      marked_list.push_back(idx);
      frame_sum += raw_s[idx];
      frame_obs++;
    end
    if (!w.frame_end) return;
    r.answer_kind = KIND_SUMMARY;
    mag = (frame_sum < 0) ? -frame_sum : frame_sum;
    if (frame_obs != 0 && mag <= eps) r.frame_rejected = 1'b1;
    else if (frame_obs != 0) begin
      den = frame_sum + eps;
      r.observed_total = 13'(frame_obs);
      foreach (marked_list[k]) begin
        idx = marked_list[k];
        if (!mark[idx]) continue;
        mark[idx] = 0;  // list may hold duplicates
        x = frame_score(raw_s[idx], frame_obs, den);
        if (last_f[idx] < 0) fast_s[idx] = x;
        else fast_s[idx] = int'((dec * fast_s[idx] + (65536 - dec) * x) / 65536);
        last_f[idx] = int'(w.frame_number);
        if (slow_c[idx] < 32'h7FFF_FFFF) slow_c[idx]++;
        old = slow_m[idx];
        slow_m[idx] = int'(old + (longint'(x) - old) / longint'(slow_c[idx]));
      end
    end
    foreach (marked_list[k]) mark[marked_list[k]] = 0;
    marked_list.delete();
    frame_sum = 0;
    frame_obs = 0;
    expected_q.push_back(r);
  endfunction

  // sender
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        in_word <= word_q.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  int stall_left;
  bit held;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      held <= 1'b0;
    end else if (!held && n_taken >= 300) begin
      held <= 1'b1;
      stall_left <= 400;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitors and watchdog
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        track_word(in_word);
        n_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected word: %p", out_word);
          n_errors++;
        end else begin
          out_word_t e;
          e = expected_q.pop_front();
          if (out_word.answer_kind !== e.answer_kind) begin
            $error("answer_kind exp %0d got %0d", e.answer_kind, out_word.answer_kind);
            n_errors++;
          end
          if (out_word.observed_total !== e.observed_total) begin
            $error("observed_total exp %0d got %0d", e.observed_total,
                   out_word.observed_total);
            n_errors++;
          end
          if (out_word.frame_rejected !== e.frame_rejected) begin
            $error("frame_rejected exp %0d got %0d", e.frame_rejected,
                   out_word.frame_rejected);
            n_errors++;
          end
          if (out_word.combined_score !== e.combined_score) begin
            $error("combined_score exp %0d got %0d", e.combined_score,
                   out_word.combined_score);
            n_errors++;
          end
          if (out_word.fast_seen !== e.fast_seen) begin
            $error("fast_seen exp %0d got %0d", e.fast_seen, out_word.fast_seen);
            n_errors++;
          end
          if (out_word.slow_seen !== e.slow_seen) begin
            $error("slow_seen exp %0d got %0d", e.slow_seen, out_word.slow_seen);
            n_errors++;
          end
          if (out_word.last_seen !== e.last_seen) begin
            $error("last_seen exp %0d got %0d", e.last_seen, out_word.last_seen);
            n_errors++;
          end
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_elem(int idx, int raw, int cnt, bit last_one);
    in_word_t w;
    w.opcode = OP_ELEMENT;
    w.entry_index = 12'(idx);
    w.raw_value = raw;
    w.hit_count = 16'(cnt);
    w.frame_number = 31'($urandom());
    w.frame_end = last_one;
    word_q.push_back(w);
    n_queued++;
  endtask

  task automatic push_query(int idx);
    in_word_t w;
    w = in_word_t'($bits(in_word_t)'({$urandom(), $urandom(), $urandom()}));
    w.opcode = OP_QUERY;
    w.entry_index = 12'(idx);
    word_q.push_back(w);
    n_queued++;
  endtask

  function automatic int pick_raw();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return -int'($urandom_range(0, 32'h30000));
      default: return $urandom_range(0, 32'h30000);
    endcase
  endfunction

  function automatic int pick_entry();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, NENT - 1);
    return $urandom_range(0, 47);
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(0, 65535);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // a well-formed frame with random content, queries mixed in
  task automatic random_frame(ref int budget);
    int len;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_query(pick_entry());
        budget--;
      end
      push_elem(pick_entry(), pick_raw(), pick_count(), k == len - 1);
      budget--;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    case (idx)
      REG_FAST_DECAY: decay_reg = val & 32'h1FFFF;
      REG_FAST_SHARE: share_reg = val & 32'h1FFFF;
      default: eps_reg = val & 32'h7FFF_FFFF;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (n_taken < n_queued || expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int budget;
    decay_reg = 58982;
    share_reg = 32768;
    eps_reg = 1;
    foreach (last_f[i]) last_f[i] = -1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: queries of fresh entries, lone extremes, repeats, removal
    push_query(0);
    push_query(NENT - 1);
    push_elem(NENT - 1, 32'h7FFF_FFFF, 65535, 1'b1);
    push_elem(0, 32'h8000_0000, 1, 1'b1);
    push_query(NENT - 1);
    push_query(0);
    push_elem(5, 100, 3, 1'b0);            // replaced below
    push_elem(5, 32'h10000, 3, 1'b0);
    push_elem(6, 32'h20000, 0, 1'b0);      // not observed
    push_elem(7, 32'h8000, 4, 1'b1);
    push_elem(8, 50, 2, 1'b0);
    push_elem(8, 50, 0, 1'b1);             // removal leaves the frame empty
    push_elem(9, 0, 0, 1'b1);              // empty frame
    push_elem(10, 1, 1, 1'b1);             // sum within eps: rejected
    push_elem(11, 32'h7FFF_FFFF, 2, 1'b0); // near-cancelling sum, scores saturate
    push_elem(12, -32'sh7FFF_FC00, 2, 1'b1);
    push_elem(5, -32'sh10000, 9, 1'b1);
    push_query(5);
    push_query(11);
    push_query(12);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_FAST_DECAY, 0);
          write_reg(REG_FAST_SHARE, 65536);
          write_reg(REG_EMPTY_THRESHOLD, 1);
        end
        1: begin
          write_reg(REG_FAST_DECAY, 65536);
          write_reg(REG_FAST_SHARE, 0);
          write_reg(REG_EMPTY_THRESHOLD, 32'h7FFF_FFFF);
        end
        2: begin
          write_reg(REG_FAST_DECAY, 32'h1FFFF);
          write_reg(REG_FAST_SHARE, 32'h1FFFF);
          write_reg(REG_EMPTY_THRESHOLD, 0);
        end
        default: begin
          write_reg(REG_FAST_DECAY, $urandom_range(0, 65536));
          write_reg(REG_FAST_SHARE, $urandom_range(0, 65536));
          write_reg(REG_EMPTY_THRESHOLD, $urandom_range(1, 32'h40000));
        end
      endcase
      budget = (phase == 1) ? 80 : 205;
      if (phase == 4) quiet = 1'b1;
      while (budget > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          push_elem(pick_entry(), pick_raw(), pick_count(), 1'b0);  // stray element
          budget--;
        end
        random_frame(budget);
        while (word_q.size() > 8) @(posedge clk);
      end
      drain();
    end

    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/piet_pkg.sv
rtl/piet_ram.sv
rtl/piet_div.sv
rtl/per_entry_importance_tracker.sv
dv/testbench.sv
